/* rtl/kci_pkg.sv */
// Shared types, register codes and defaults for the keyframe color interpolator.
package kci_pkg;

    localparam int DEF_MAX_KEYS  = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TIME_W     = 31;
    localparam int REPEAT_W   = 25;
    localparam int KCOUNT_W   = 5;
    localparam int SLOT_W     = 4;
    localparam int COLOR_W    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FILL  = 3'd4;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [SLOT_W-1:0]   key_index;
        logic [COLOR_W-1:0]  key_color;
        logic [TIME_W-1:0]   elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       applies_to_fill;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FRAME,
        ST_MUL,
        ST_ADDR,
        ST_RD_HI,
        ST_BLEND
    } t_state;

    typedef struct packed {
        logic div_step;
        logic frame_en;
        logic mul_en;
        logic addr_en;
        logic rd_hi;
        logic blend_en;
    } t_ctl;

endpackage

/* rtl/kci_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module kci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/keyframe_color_interpolator.sv */
// Top level of the keyframe color interpolator: control, divider, blend datapath.
//
// Load items (opcode 0) write one ARGB keyframe into the key table without
// leaving idle; a new item is accepted right in the next cycle. Evaluate items
// (opcode 1) map elapsed_ms to a frame, pick the two neighbouring keyframes and
// blend each channel linearly. An evaluate before start_time or after the
// repeat limit has been passed gives no result and leaves the block idle. Any other
// evaluate keeps busy high until its blend is done, so the next item waits for
// it; the pace is set by the restoring divider that normalizes the time against
// run_time, one quotient bit per cycle over 31 + FRAC_BITS bits. With run_time
// zero the divider is skipped. After the divider come the repeat check, one
// multiply for the key position, two reads of the key table (low key, then
// high key) and the blend.
// The result appears on o_res for exactly one cycle with o_res_strobe high;
// there is no backpressure, so the receiver must take it in that cycle. The
// strobe cycle already has busy low, so the next item can be accepted while the
// result is shown. Write configuration only while the block is idle. Reading a
// key slot that was never loaded gives an undefined color.
module keyframe_color_interpolator #(
    parameter int MAX_KEYS  = kci_pkg::DEF_MAX_KEYS,
    parameter int FRAC_BITS = kci_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                start,
    output logic                                busy,
    input  kci_pkg::t_in                        i_in,
    // result channel
    output logic                                o_res_strobe,
    output kci_pkg::t_out                       o_res,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kci_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kci_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import kci_pkg::*;

    // Quotient width: time difference shifted up by the fraction bits
    localparam int QW  = TIME_W + FRAC_BITS;
    localparam int CW  = $clog2(QW + 1);
    // Key table address width; keys - 1 fits in it as well
    localparam int KIW = $clog2(MAX_KEYS);
    // Width of the key position (fraction bits, one integer bit, key index)
    localparam int PW  = FRAC_BITS + 1 + KIW;
    // Width of a blend accumulator
    localparam int VW  = FRAC_BITS + 11;

    localparam logic [QW-1:0] OneQ = QW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] OneP = PW'(1) << FRAC_BITS;

    // Configuration registers
    logic [TIME_W-1:0]   r_start_time;
    logic [TIME_W-1:0]   r_run_time;
    logic [REPEAT_W-1:0] r_repeat_count;
    logic [KCOUNT_W-1:0] r_key_count;
    logic                r_target_fill;

    // Control state
    t_state              r_state;
    t_state              n_state;
    t_ctl                ctl;
    logic                r_finished;
    logic                r_res_strobe;
    logic [CW-1:0]       r_cnt;

    // Datapath registers
    logic [TIME_W-1:0]   r_rem;
    logic [QW-1:0]       r_dvd;
    logic [QW-1:0]       r_quo;
    logic [FRAC_BITS:0]  r_percent;
    logic [PW-1:0]       r_pos;
    logic [KIW-1:0]      r_hi;
    logic [FRAC_BITS:0]  r_morph;
    logic [COLOR_W-1:0]  r_clo;
    t_out                r_res;

    // Combinational helpers
    logic                accept;
    logic                eval_go;
    logic [TIME_W-1:0]   diff;
    logic [TIME_W:0]     trial;
    logic                trial_ge;
    logic [QW-1:0]       rep_ext;
    logic                rep_hit;
    logic [QW-1:0]       frame;
    logic [KIW-1:0]      km1;
    logic [KIW-1:0]      lo;
    logic [KIW-1:0]      hi;
    logic [FRAC_BITS:0]  morph;
    logic                ram_we;
    logic [KIW-1:0]      ram_waddr;
    logic [KIW-1:0]      ram_raddr;
    logic [COLOR_W-1:0]  ram_rdata;

    // Linear blend of one 8-bit channel; the value never goes negative
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [FRAC_BITS:0] m);
        logic signed [8:0]          d;
        logic signed [FRAC_BITS+1:0] ms;
        logic signed [VW-1:0]       base;
        logic signed [VW-1:0]       v;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        ms   = $signed({1'b0, m});
        base = $signed(VW'({a, {FRAC_BITS{1'b0}}}));
        v    = VW'(d) * VW'(ms) + base;
        return v[FRAC_BITS+7:FRAC_BITS];
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign diff        = i_in.elapsed_ms - r_start_time;

    // Drop evaluates before start time or after the repeat limit was passed
    assign eval_go = accept && (i_in.opcode == OP_EVAL) &&
                     !(i_in.elapsed_ms < r_start_time) && !r_finished;

    // Loads write the table at the accept edge; evaluates read it only in later
    // states while busy holds off new items, so a load never overlaps a read of the same slot.
    assign ram_we    = accept && (i_in.opcode == OP_LOAD) &&
                       (32'(i_in.key_index) < MAX_KEYS);
    assign ram_waddr = KIW'(i_in.key_index);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (eval_go) begin
                    n_state = (r_run_time == '0) ? ST_FRAME : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ST_FRAME;
                end
            end
            ST_FRAME: n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_RD_HI;
            ST_RD_HI: n_state = ST_BLEND;
            ST_BLEND: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State decode
    // ------------------------------------------------------------------
    always_comb begin
        ctl = '0;
        unique case (r_state)
            ST_IDLE:  ;
            ST_DIV:   ctl.div_step = 1'b1;
            ST_FRAME: ctl.frame_en = 1'b1;
            ST_MUL:   ctl.mul_en   = 1'b1;
            ST_ADDR:  ctl.addr_en  = 1'b1;
            ST_RD_HI: ctl.rd_hi    = 1'b1;
            ST_BLEND: ctl.blend_en = 1'b1;
            default:  ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath combinational parts
    // ------------------------------------------------------------------
    // One restoring division step: shift in the next dividend bit, subtract
    assign trial    = {r_rem, r_dvd[QW-1]};
    assign trial_ge = (trial >= {1'b0, r_run_time});

    // Repeat limit rescaled to the frame's fraction bits
    assign rep_ext = QW'(r_repeat_count[REPEAT_W-2:0]) << (FRAC_BITS - 8);
    assign rep_hit = !r_repeat_count[REPEAT_W-1] && (rep_ext < r_quo);
    assign frame   = rep_hit ? rep_ext : r_quo;

    // Clamp the key count to 1..MAX_KEYS, then keep keys - 1
    always_comb begin
        if (r_key_count == '0) begin
            km1 = '0;
        end else if (32'(r_key_count) > MAX_KEYS) begin
            km1 = KIW'(MAX_KEYS - 1);
        end else begin
            km1 = KIW'(r_key_count - KCOUNT_W'(1));
        end
    end

    // Neighbouring keys and the morph factor between them
    assign lo    = r_pos[FRAC_BITS+KIW-1:FRAC_BITS];
    assign hi    = lo + KIW'(r_pos[FRAC_BITS-1:0] != '0);
    assign morph = (r_pos > OneP) ? {1'b0, r_pos[FRAC_BITS-1:0]} : r_pos[FRAC_BITS:0];

    assign ram_raddr = ctl.rd_hi ? r_hi : lo;

    kci_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.key_color),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_finished     <= 1'b0;
            r_res_strobe   <= 1'b0;
            r_start_time   <= '0;
            r_run_time     <= '0;
            r_repeat_count <= REPEAT_W'(-256);
            r_key_count    <= KCOUNT_W'(1);
            r_target_fill  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_res_strobe <= ctl.blend_en;
            // Latch the limit hit; stay silent until reset from then on
            if (ctl.frame_en && rep_hit) begin
                r_finished <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_START_TIME:   r_start_time   <= i_cfg_data[TIME_W-1:0];
                    REG_RUN_TIME:     r_run_time     <= i_cfg_data[TIME_W-1:0];
                    REG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[REPEAT_W-1:0];
                    REG_KEY_COUNT:    r_key_count    <= i_cfg_data[KCOUNT_W-1:0];
                    REG_TARGET_FILL:  r_target_fill  <= i_cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            // Load the divider; a zero run time leaves the quotient at zero
            r_rem <= '0;
            r_dvd <= {diff, {FRAC_BITS{1'b0}}};
            r_quo <= '0;
            r_cnt <= CW'(QW);
        end else if (ctl.div_step) begin
            r_rem <= trial_ge ? TIME_W'(trial - {1'b0, r_run_time}) : trial[TIME_W-1:0];
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], trial_ge};
            r_cnt <= r_cnt - CW'(1);
        end

        // Keep only the fraction of frames beyond one pass
        if (ctl.frame_en) begin
            r_percent <= (frame > OneQ) ? {1'b0, frame[FRAC_BITS-1:0]} : frame[FRAC_BITS:0];
        end

        if (ctl.mul_en) begin
            r_pos <= PW'(r_percent) * PW'(km1);
        end

        if (ctl.addr_en) begin
            r_hi    <= hi;
            r_morph <= morph;
        end

        // Read data of the low key arrives while the high key is addressed
        if (ctl.rd_hi) begin
            r_clo <= ram_rdata;
        end

        if (ctl.blend_en) begin
            r_res.alpha           <= blend(r_clo[31:24], ram_rdata[31:24], r_morph);
            r_res.red             <= blend(r_clo[23:16], ram_rdata[23:16], r_morph);
            r_res.green           <= blend(r_clo[15:8],  ram_rdata[15:8],  r_morph);
            r_res.blue            <= blend(r_clo[7:0],   ram_rdata[7:0],   r_morph);
            r_res.applies_to_fill <= r_target_fill;
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A result strobe follows the blend cycle and nothing else
    a_strobe_after_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(r_state == ST_BLEND))
        else $error("result strobe without a preceding blend");

    // The partial remainder stays below the divisor during division
    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_run_time))
        else $error("divider remainder not below run time");

    // Once the repeat limit is passed the block stays finished until reset
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_finished))
        else $error("finished flag cleared without reset");

    // The morph factor never exceeds one
    a_morph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_HI) |-> (r_morph <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("morph factor above one");

endmodule

/* sim/keyframe_color_interpolator_test.sv */
// Self-checking testbench for the keyframe color interpolator.
`timescale 1ns / 1ps

module keyframe_color_interpolator_test;
    import kci_pkg::*;

    localparam int          FRAC          = DEF_FRAC_BITS;
    localparam int          KEY_SLOTS     = DEF_MAX_KEYS;
    localparam logic [63:0] ONE           = 64'd1 << FRAC;
    localparam logic [63:0] FRAC_MASK     = ONE - 64'd1;
    localparam int          SETTLE_CYCLES = 36 + FRAC + 8;
    localparam int          TIMEOUT_NS    = 4_000_000;
    localparam int          PRINT_LIMIT   = 40;
    localparam logic [30:0] TIME_MAX      = 31'h7FFF_FFFF;
    localparam logic [24:0] REPEAT_FOREVER = 25'h1FF_FF00;
    localparam logic [24:0] REPEAT_MOST_NEG = 25'h100_0000;
    localparam logic [24:0] REPEAT_MAX    = 25'h0FF_FFFF;
    // No register sits at this index; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in                   item_bus    = '0;
    logic                  o_res_strobe;
    t_out                  o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    keyframe_color_interpolator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (item_bus),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // Animation settings as last written, and the shadow of the block's state.
    logic [TIME_W-1:0]   cfg_start  = '0;
    logic [TIME_W-1:0]   cfg_run    = '0;
    logic [REPEAT_W-1:0] cfg_repeat = REPEAT_FOREVER;
    logic [KCOUNT_W-1:0] cfg_keys   = 5'd1;
    logic                cfg_fill   = 1'b0;
    logic [COLOR_W-1:0]  key_table [KEY_SLOTS];
    logic                anim_done  = 1'b0;
    // Slots queued for loading so far; an evaluate never reads a slot outside this set.
    logic                slot_loaded [KEY_SLOTS];

    t_in  pending_items   [$];
    t_out expected_colors [$];
    logic item_taken      = 1'b0;
    int   sender_idle_pct = 13;
    int   error_count     = 0;
    int   colors_checked  = 0;
    int   loads_queued    = 0;
    int   evals_queued    = 0;
    int   settings_used   = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Clamp the key count the way the block does: zero acts as one, big counts as a full table.
    function automatic int unsigned keys_in_use();
        if (cfg_keys == '0) return 1;
        if (cfg_keys > KEY_SLOTS) return KEY_SLOTS;
        return cfg_keys;
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] from_c, logic [7:0] to_c,
                                               logic [63:0] morph);
        longint acc;
        acc = longint'(from_c) * longint'(ONE) + (longint'(to_c) - longint'(from_c)) * longint'(morph);
        if (acc < 0) acc = 0;
        return 8'(acc >> FRAC);
    endfunction

    // Update the shadow state for one item; return 1 with the color when one is due.
    function automatic bit predict_blend(input t_in item, output t_out res);
        logic [63:0] span, frame, repeat_fx, percent, pos, morph;
        int unsigned lo_key, hi_key;
        res = '0;
        if (item.opcode == OP_LOAD) begin
            key_table[item.key_index] = item.key_color;
            return 1'b0;
        end
        if (item.elapsed_ms < cfg_start || anim_done) return 1'b0;

        span  = 64'(item.elapsed_ms) - 64'(cfg_start);
        frame = (cfg_run == '0) ? 64'd0 : (span << FRAC) / 64'(cfg_run);
        // A non-negative repeat limit caps the frame and ends the animation once passed.
        if (!cfg_repeat[REPEAT_W-1]) begin
            repeat_fx = 64'(cfg_repeat) << (FRAC - 8);
            if (repeat_fx < frame) begin
                anim_done = 1'b1;
                frame     = repeat_fx;
            end
        end
        percent = (frame > ONE) ? (frame & FRAC_MASK) : frame;
        pos     = percent * 64'(keys_in_use() - 1);
        lo_key  = int'(pos >> FRAC);
        hi_key  = lo_key + (((pos & FRAC_MASK) != 0) ? 1 : 0);
        if (lo_key > KEY_SLOTS - 1) lo_key = KEY_SLOTS - 1;
        if (hi_key > KEY_SLOTS - 1) hi_key = KEY_SLOTS - 1;
        morph   = (pos > ONE) ? (pos & FRAC_MASK) : pos;

        res.alpha = mix_channel(key_table[lo_key][31:24], key_table[hi_key][31:24], morph);
        res.red   = mix_channel(key_table[lo_key][23:16], key_table[hi_key][23:16], morph);
        res.green = mix_channel(key_table[lo_key][15:8],  key_table[hi_key][15:8],  morph);
        res.blue  = mix_channel(key_table[lo_key][7:0],   key_table[hi_key][7:0],   morph);
        res.applies_to_fill = cfg_fill;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            if (error_count < PRINT_LIMIT)
                $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Monitor: check the color shown this cycle, then record any item taken at this edge.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            item_taken = 1'b0;
        end else begin
            if (o_res_strobe) begin
                if (expected_colors.size() == 0) begin
                    if (error_count < PRINT_LIMIT)
                        $display("%0d ns: unexpected color, expected none, actual %h",
                                 $time, o_res);
                    error_count++;
                end else begin
                    want = expected_colors.pop_front();
                    check_field("alpha", want.alpha, o_res.alpha);
                    check_field("red", want.red, o_res.red);
                    check_field("green", want.green, o_res.green);
                    check_field("blue", want.blue, o_res.blue);
                    check_field("applies_to_fill", 8'(want.applies_to_fill),
                                8'(o_res.applies_to_fill));
                    colors_checked++;
                end
            end
            item_taken = start && !busy;
            if (item_taken && predict_blend(item_bus, want))
                expected_colors.push_back(want);
        end
    end

    // Driver: hold an offered item until it is taken, then offer the next or idle.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || item_taken)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                item_bus <= pending_items.pop_front();
                start    <= 1'b1;
            end else begin
                start    <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_START_TIME:   cfg_start  = data[TIME_W-1:0];
            REG_RUN_TIME:     cfg_run    = data[TIME_W-1:0];
            REG_REPEAT_COUNT: cfg_repeat = data[REPEAT_W-1:0];
            REG_KEY_COUNT:    cfg_keys   = data[KCOUNT_W-1:0];
            REG_TARGET_FILL:  cfg_fill   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_animation(input logic [TIME_W-1:0] t0, input logic [TIME_W-1:0] run,
                                 input logic [REPEAT_W-1:0] rep, input logic [KCOUNT_W-1:0] keys,
                                 input logic fill);
        write_reg(REG_START_TIME, CFG_DATA_W'(t0));
        write_reg(REG_RUN_TIME, CFG_DATA_W'(run));
        write_reg(REG_REPEAT_COUNT, CFG_DATA_W'(rep));
        write_reg(REG_KEY_COUNT, CFG_DATA_W'(keys));
        write_reg(REG_TARGET_FILL, CFG_DATA_W'(fill));
        settings_used++;
    endtask

    task automatic queue_load(input int unsigned slot, input logic [COLOR_W-1:0] color);
        t_in item;
        item.opcode     = OP_LOAD;
        item.key_index  = SLOT_W'(slot);
        item.key_color  = color;
        item.elapsed_ms = TIME_W'($urandom);
        slot_loaded[slot] = 1'b1;
        pending_items.push_back(item);
        loads_queued++;
    endtask

    // Fill any key slot the evaluate may read before queuing it.
    task automatic queue_eval(input logic [TIME_W-1:0] now);
        t_in item;
        for (int s = 0; s < keys_in_use(); s++)
            if (!slot_loaded[s]) queue_load(s, $urandom);
        item.opcode     = OP_EVAL;
        item.key_index  = SLOT_W'($urandom);
        item.key_color  = $urandom;
        item.elapsed_ms = now;
        pending_items.push_back(item);
        evals_queued++;
    endtask

    // Wait until every item is in and every color is out, then let trailing work finish.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || busy || expected_colors.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Pick an evaluate time: mostly within a few passes of start, some before start,
    // some on exact pass boundaries, never past limit.
    function automatic logic [TIME_W-1:0] pick_time(input longint limit);
        longint      span  = limit - longint'(cfg_start);
        longint      reach = span;
        longint      d;
        int unsigned roll  = $urandom_range(99);
        if (roll < 10 && cfg_start != '0) return TIME_W'($urandom_range(32'(cfg_start) - 1, 0));
        if (roll < 15) return cfg_start;
        if (roll < 20) return TIME_W'(limit);
        if (roll < 35 && cfg_run != '0) begin
            d = longint'(cfg_run) * longint'($urandom_range(4));
        end else begin
            if (roll < 85 && cfg_run != '0 && 3 * longint'(cfg_run) < span)
                reach = 3 * longint'(cfg_run);
            d = longint'($urandom_range(32'(reach), 0));
        end
        if (d > span) d = span;
        return TIME_W'(longint'(cfg_start) + d);
    endfunction

    task automatic random_phase(input int n_items);
        logic [TIME_W-1:0]   t0, run;
        logic [REPEAT_W-1:0] rep;
        logic [KCOUNT_W-1:0] keys;
        longint              limit;
        case ($urandom_range(3))
            0:       t0 = '0;
            1:       t0 = TIME_W'($urandom_range(1000));
            2:       t0 = TIME_W'($urandom);
            default: t0 = TIME_MAX - TIME_W'($urandom_range(50000));
        endcase
        case ($urandom_range(5))
            0:       run = '0;
            1:       run = 31'd1;
            2:       run = TIME_W'($urandom_range(2000, 1));
            3:       run = TIME_W'($urandom_range(100000, 1));
            4:       run = TIME_W'($urandom);
            default: run = TIME_MAX;
        endcase
        case ($urandom_range(5))
            0:       rep = REPEAT_FOREVER;
            1:       rep = REPEAT_MOST_NEG;
            2:       rep = {1'b1, 24'($urandom)};
            3:       rep = REPEAT_W'($urandom_range(2048));
            default: rep = REPEAT_W'($urandom_range(32'(REPEAT_MAX)));
        endcase
        if ($urandom_range(4) != 0) keys = KCOUNT_W'($urandom_range(KEY_SLOTS, 1));
        else if ($urandom_range(1) != 0) keys = '0;
        else keys = KCOUNT_W'($urandom_range(31, KEY_SLOTS + 1));
        set_animation(t0, run, rep, keys, 1'($urandom));

        // Keep a finite repeat limit from being passed: the end of the animation is
        // one-shot and is saved for the last phase.
        limit = longint'(TIME_MAX);
        if (!rep[REPEAT_W-1] && run != '0)
            limit = longint'(t0) + ((longint'(rep) * longint'(run)) >> 8);
        if (limit > longint'(TIME_MAX)) limit = longint'(TIME_MAX);

        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(3) == 0) queue_load($urandom_range(KEY_SLOTS - 1), $urandom);
            else queue_eval(pick_time(limit));
        end
        drain();
    endtask

    initial begin
        foreach (key_table[s]) key_table[s] = '0;
        foreach (slot_loaded[s]) slot_loaded[s] = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no run time and one key, so every evaluate shows slot 0.
        queue_load(0, 32'hFFFF_FFFF);
        queue_eval('0);
        queue_eval(TIME_MAX);
        drain();

        // Four keys over one second: before start, pass start, mid-key, pass end, wrap.
        set_animation(31'd1000, 31'd1000, REPEAT_FOREVER, 5'd4, 1'b1);
        queue_load(1, 32'h0000_0000);
        queue_load(2, 32'hA5C3_E10F);
        queue_load(3, 32'h5A3C_1EF0);
        queue_eval(31'd999);
        queue_eval(31'd1000);
        queue_eval(31'd1001);
        queue_eval(31'd1500);
        queue_eval(31'd2000);
        queue_eval(31'd2500);
        queue_eval(31'd2999);
        drain();

        // Longest run time, largest repeat limit, key count above the table size.
        write_reg(REG_UNMAPPED, $urandom);
        set_animation('0, TIME_MAX, REPEAT_MAX, 5'd31, 1'b0);
        queue_eval(TIME_MAX);
        queue_eval(31'h3FFF_FFFF);
        drain();

        // Latest start, shortest run time, key count zero, most negative repeat limit.
        set_animation(TIME_MAX, 31'd1, REPEAT_MOST_NEG, 5'd0, 1'b1);
        queue_eval(TIME_MAX - 31'd1);
        queue_eval(TIME_MAX);
        drain();

        // Random settings; sender pauses seldom, then often, then never.
        for (int p = 0; p < 12; p++) begin
            sender_idle_pct = (p < 4) ? 13 : ((p < 8) ? 46 : 0);
            random_phase(170);
        end

        // End of the animation: at the limit still runs, just past it gives the last
        // color, and from then on evaluates stay silent.
        sender_idle_pct = 13;
        set_animation('0, 31'd100, 25'h180, 5'd3, 1'b1);
        queue_eval(31'd50);
        queue_eval(31'd150);
        queue_eval(31'd151);
        queue_eval(31'd10);
        queue_eval(31'd200);
        queue_load(5, $urandom);
        queue_eval(31'd300);
        drain();

        $display("Covered %0d keyframe loads and %0d evaluates under %0d animation settings;",
                 loads_queued, evals_queued, settings_used);
        $display("%0d colors compared, %0d mismatches.", colors_checked, error_count);
        if (error_count == 0 && expected_colors.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/kci_pkg.sv
rtl/kci_ram.sv
rtl/keyframe_color_interpolator.sv
sim/keyframe_color_interpolator_test.sv
